FILE: rtl/emkv_pkg.sv
// Shared types and constants for the exact-match key/value table.
`timescale 1ns / 1ps
package emkv_pkg;

   // Fixed field widths on the stream ports
   localparam int CMD_W       = 2;
   localparam int FIELD_W     = 64;
   localparam int COND_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int CAP_W       = 9;
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 72;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   // Defaults for the top-level parameters
   localparam int DEF_TABLE_ENTRIES = 256;
   localparam int DEF_KEY_WIDTH     = 64;
   localparam int DEF_VALUE_WIDTH   = 64;

   // Condition bits of an update
   localparam int COND_IF_ABSENT  = 0;
   localparam int COND_IF_PRESENT = 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_UPDATE = 2'd1,
      CMD_DELETE = 2'd2
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EXISTS    = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Controller to datapath
   typedef struct packed {
      logic load_req;
      logic addr_clr;
      logic addr_inc;
      logic clear_wr;
      logic scan_rd;
      logic val_rd;
      logic commit;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic addr_last;
      logic rsp_free;
   } dp_status_type;

endpackage

FILE: rtl/emkv_ctrl.sv
// Sequencer for clearing, scanning and committing table transactions.
`timescale 1ns / 1ps
module emkv_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  emkv_pkg::dp_status_type dp_status,
   output emkv_pkg::ctl_cmd_type   ctl_cmd
);
   import emkv_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_SCAN   = 6'b000100,
      S_SETTLE = 6'b001000,
      S_DECIDE = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctl_cmd    = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            ctl_cmd.clear_wr = 1'b1;
            ctl_cmd.addr_inc = 1'b1;
            if (dp_status.addr_last) begin
               ctl_cmd.addr_clr = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl_cmd.load_req = 1'b1;
               ctl_cmd.addr_clr = 1'b1;
               state_in         = S_SCAN;
            end
         end
         S_SCAN: begin
            ctl_cmd.scan_rd  = 1'b1;
            ctl_cmd.addr_inc = 1'b1;
            if (dp_status.addr_last) begin
               ctl_cmd.addr_clr = 1'b1;
               state_in         = S_SETTLE;
            end
         end
         // last key read is compared here
         S_SETTLE: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            ctl_cmd.val_rd = 1'b1;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (dp_status.rsp_free) begin
               ctl_cmd.commit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

FILE: rtl/emkv_datapath.sv
// Key/value memories, scan compare, decision logic and result register.
`timescale 1ns / 1ps
module emkv_datapath #(
   parameter int TABLE_ENTRIES = emkv_pkg::DEF_TABLE_ENTRIES,
   parameter int KEY_WIDTH     = emkv_pkg::DEF_KEY_WIDTH,
   parameter int VALUE_WIDTH   = emkv_pkg::DEF_VALUE_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [emkv_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                              csr_valid,
   input  logic [emkv_pkg::CAP_W-1:0]        csr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [emkv_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  emkv_pkg::ctl_cmd_type             ctl_cmd,
   output emkv_pkg::dp_status_type           dp_status
);
   import emkv_pkg::*;

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int MW = (CW > CAP_W) ? CW : CAP_W;

   // Key store entry: {valid, key}
   logic [KEY_WIDTH:0]   kmem [TABLE_ENTRIES];
   logic [VALUE_WIDTH-1:0] vmem [TABLE_ENTRIES];

   // Request fields
   command_type            cmd_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic [COND_W-1:0]      cond_ff;

   logic [AW-1:0]          addr_ff, addr_in;
   logic                   rd_vld_ff;
   logic [AW-1:0]          rd_idx_ff;
   logic [KEY_WIDTH:0]     kq_ff;
   logic [VALUE_WIDTH-1:0] vq_ff;

   logic                   found_ff;
   logic [AW-1:0]          found_idx_ff;
   logic                   free_ff;
   logic [AW-1:0]          free_idx_ff;

   logic [CW-1:0]          count_ff;
   logic [CAP_W-1:0]       cap_ff;

   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [FIELD_W-1:0]     rsp_value_ff;

   // Commit decision
   status_type             st;
   logic [FIELD_W-1:0]     rv;
   logic                   k_we, v_we, cnt_inc, cnt_dec;
   logic [AW-1:0]          k_addr, v_addr;
   logic [KEY_WIDTH:0]     k_data;
   logic [MW-1:0]          cap_x, cap_eff;
   logic                   at_cap;
   logic                   hit, empty_slot;

   assign dp_status.addr_last = (addr_ff == AW'(TABLE_ENTRIES - 1));
   assign dp_status.rsp_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      addr_in = addr_ff;
      if (ctl_cmd.addr_clr) begin
         addr_in = '0;
      end else if (ctl_cmd.addr_inc) begin
         addr_in = addr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff   <= '0;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
         free_ff   <= 1'b0;
         count_ff  <= '0;
         cap_ff    <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff   <= addr_in;
         rd_vld_ff <= ctl_cmd.scan_rd;
         if (ctl_cmd.load_req) begin
            found_ff <= 1'b0;
            free_ff  <= 1'b0;
         end else if (rd_vld_ff) begin
            if (hit && !found_ff) begin
               found_ff <= 1'b1;
            end
            if (empty_slot && !free_ff) begin
               free_ff <= 1'b1;
            end
         end
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
         if (ctl_cmd.commit) begin
            if (cnt_inc) begin
               count_ff <= count_ff + CW'(1);
            end else if (cnt_dec && count_ff != '0) begin
               count_ff <= count_ff - CW'(1);
            end
         end
         if (ctl_cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ctl_cmd.load_req) begin
         cmd_ff  <= command_type'(req_tdata[CMD_W-1:0]);
         key_ff  <= req_tdata[CMD_W +: KEY_WIDTH];
         val_ff  <= req_tdata[CMD_W + FIELD_W +: VALUE_WIDTH];
         cond_ff <= req_tdata[CMD_W + 2*FIELD_W +: COND_W];
      end
      rd_idx_ff <= addr_ff;
      if (rd_vld_ff && hit && !found_ff) begin
         found_idx_ff <= rd_idx_ff;
      end
      if (rd_vld_ff && empty_slot && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (ctl_cmd.commit) begin
         rsp_status_ff <= st;
         rsp_value_ff  <= rv;
      end
   end

   // Key store: one write, one registered read
   always_ff @(posedge clock) begin
      if (ctl_cmd.clear_wr) begin
         kmem[addr_ff] <= '0;
      end else if (ctl_cmd.commit && k_we) begin
         kmem[k_addr] <= k_data;
      end
      kq_ff <= kmem[addr_ff];
   end

   // Value store
   always_ff @(posedge clock) begin
      if (ctl_cmd.commit && v_we) begin
         vmem[v_addr] <= val_ff;
      end
      if (ctl_cmd.val_rd) begin
         vq_ff <= vmem[found_idx_ff];
      end
   end

   assign hit        = kq_ff[KEY_WIDTH] && (kq_ff[KEY_WIDTH-1:0] == key_ff);
   assign empty_slot = !kq_ff[KEY_WIDTH];

   // Effective capacity is limited to the table size
   always_comb begin
      cap_x   = MW'(cap_ff);
      cap_eff = (cap_x > MW'(TABLE_ENTRIES)) ? MW'(TABLE_ENTRIES) : cap_x;
      at_cap  = (MW'(count_ff) >= cap_eff);
   end

   always_comb begin
      st      = ST_OK;
      rv      = '0;
      k_we    = 1'b0;
      v_we    = 1'b0;
      k_addr  = found_idx_ff;
      v_addr  = found_idx_ff;
      k_data  = '0;
      cnt_inc = 1'b0;
      cnt_dec = 1'b0;
      case (cmd_ff)
         CMD_LOOKUP: begin
            if (found_ff) begin
               rv = FIELD_W'(vq_ff);
            end else begin
               st = ST_NOT_FOUND;
            end
         end
         CMD_UPDATE: begin
            if (found_ff && cond_ff[COND_IF_ABSENT]) begin
               st = ST_EXISTS;
            end else if (!found_ff && cond_ff[COND_IF_PRESENT]) begin
               st = ST_NOT_FOUND;
            end else if (found_ff) begin
               v_we = 1'b1;
            end else if (at_cap || !free_ff) begin
               st = ST_FULL;
            end else begin
               k_we    = 1'b1;
               v_we    = 1'b1;
               k_addr  = free_idx_ff;
               v_addr  = free_idx_ff;
               k_data  = {1'b1, key_ff};
               cnt_inc = 1'b1;
            end
         end
         CMD_DELETE: begin
            if (found_ff) begin
               k_we    = 1'b1;
               cnt_dec = 1'b1;
            end
         end
         default: begin
            st = ST_OK;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - STATUS_W - FIELD_W){1'b0}}, rsp_value_ff, rsp_status_ff};

endmodule

FILE: rtl/exact_match_key_value_table_top.sv
// Top level of the exact-match key/value table.
//
//   channel   ports                          direction  carries
//   req       req_tvalid/tready/tdata[135:0]  in         one table command
//   rsp       rsp_tvalid/tready/tdata[71:0]   out        status and read value
//   csr       csr_valid/ready/data[8:0]       in         max_live_entries
//
// A transaction scans the key store one entry per cycle after acceptance,
// then compares the last key, reads the value and commits the result;
// the next request is taken in the cycle after the commit. A clearing pass
// after reset zeroes every key store entry; req_tready stays low meanwhile.
// csr writes are taken at any time. A result waiting on rsp_tready does not
// block the next request; only its commit waits for the result register.
`timescale 1ns / 1ps
module exact_match_key_value_table_top #(
   parameter int TABLE_ENTRIES = emkv_pkg::DEF_TABLE_ENTRIES,
   parameter int KEY_WIDTH     = emkv_pkg::DEF_KEY_WIDTH,
   parameter int VALUE_WIDTH   = emkv_pkg::DEF_VALUE_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [1:0] command, [65:2] key, [129:66] new_value, [131:130] update_condition
   input  logic [emkv_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] status, [65:2] read_value
   output logic [emkv_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [emkv_pkg::CAP_W-1:0]       csr_data
);
   import emkv_pkg::*;

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   emkv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .ctl_cmd    (ctl_cmd)
   );

   emkv_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .KEY_WIDTH     (KEY_WIDTH),
      .VALUE_WIDTH   (VALUE_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .ctl_cmd    (ctl_cmd),
      .dp_status  (dp_status)
   );

   // A commit only happens when the result register can take it
   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.commit |-> dp_status.rsp_free)
      else $error("commit while result register occupied");

   // Every commit shows up as a result
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.commit |=> rsp_tvalid)
      else $error("commit did not produce a result");

   // One transaction in flight at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in progress");

endmodule

FILE: test/tb_top.sv
// Testbench for the exact-match key/value table: directed script, then random traffic.
`timescale 1ns / 1ps
module tb_top;
   import emkv_pkg::*;

   localparam int TABLE_ENTRIES = DEF_TABLE_ENTRIES;
   localparam logic [CMD_W-1:0]   CMD_UNUSED        = 2'd3;
   localparam logic [COND_W-1:0]  COND_NONE         = 2'b00;
   localparam logic [COND_W-1:0]  COND_ABSENT_ONLY  = 2'b01 << COND_IF_ABSENT;
   localparam logic [COND_W-1:0]  COND_PRESENT_ONLY = 2'b01 << COND_IF_PRESENT;
   localparam logic [COND_W-1:0]  COND_BOTH         = COND_ABSENT_ONLY | COND_PRESENT_ONLY;
   localparam logic [FIELD_W-1:0] ALL_ONES  = '1;
   localparam logic [FIELD_W-1:0] PATTERN_5 = 64'h5555_5555_5555_5555;
   localparam logic [FIELD_W-1:0] PATTERN_A = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam int HOLD_OFF_CYCLES = 2000;

   typedef struct packed {
      status_type         status;
      logic [FIELD_W-1:0] value;
   } table_result_type;

   typedef struct {
      bit                 is_cap;
      logic [CAP_W-1:0]   cap;
      logic [CMD_W-1:0]   cmd;
      logic [FIELD_W-1:0] key;
      logic [FIELD_W-1:0] value;
      logic [COND_W-1:0]  cond;
      bit                 typed;
      table_result_type   result;
   } script_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CAP_W-1:0]       csr_data   = '0;

   // predictor state
   logic [FIELD_W-1:0] stored_value [logic [FIELD_W-1:0]];
   logic [CAP_W-1:0]   capacity_setting = CAP_RESET;
   table_result_type   expected_results [$];
   logic [FIELD_W-1:0] key_pool [$];
   script_row_type     script [$];

   int error_count  = 0;
   int idle_pct     = 25;
   bit hold_off_req = 1'b0;

   exact_match_key_value_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic table_result_type apply_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [FIELD_W-1:0] key,
                                                      input logic [FIELD_W-1:0] value,
                                                      input logic [COND_W-1:0] cond);
      table_result_type res;
      bit present;
      int cap;
      res.status = ST_OK;
      res.value  = '0;
      present = stored_value.exists(key);
      cap = (capacity_setting > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(capacity_setting);
      if (cmd == CMD_LOOKUP) begin
         if (present) res.value = stored_value[key];
         else res.status = ST_NOT_FOUND;
      end else if (cmd == CMD_UPDATE) begin
         if (present && cond[COND_IF_ABSENT]) res.status = ST_EXISTS;
         else if (!present && cond[COND_IF_PRESENT]) res.status = ST_NOT_FOUND;
         else if (present) stored_value[key] = value;
         else if (stored_value.num() >= cap) res.status = ST_FULL;
         else stored_value[key] = value;
      end else if (cmd == CMD_DELETE) begin
         if (present) stored_value.delete(key);
      end
      return res;
   endfunction

   function automatic void step(input logic [CMD_W-1:0] cmd, input logic [FIELD_W-1:0] key,
                                input logic [FIELD_W-1:0] value, input logic [COND_W-1:0] cond,
                                input bit typed = 1'b0, input status_type status = ST_OK,
                                input logic [FIELD_W-1:0] read_value = '0);
      script_row_type r;
      r.is_cap = 1'b0;
      r.cap = '0;
      r.cmd = cmd;
      r.key = key;
      r.value = value;
      r.cond = cond;
      r.typed = typed;
      r.result.status = status;
      r.result.value = read_value;
      script.push_back(r);
   endfunction

   function automatic void cap_step(input logic [CAP_W-1:0] cap);
      script_row_type r;
      r = '{default: '0};
      r.is_cap = 1'b1;
      r.cap = cap;
      script.push_back(r);
   endfunction

   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [FIELD_W-1:0] key,
                               input logic [FIELD_W-1:0] value, input logic [COND_W-1:0] cond,
                               input bit typed, input table_result_type typed_result);
      table_result_type predicted;
      req_tdata  <= {4'b0, cond, value, key, cmd};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = apply_command(cmd, key, value, cond);
      expected_results.push_back(typed ? typed_result : predicted);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_W-1:0] cap);
      wait_drained();
      csr_data  <= cap;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      capacity_setting = cap;
   endtask

   // fresh_pct: share of never-seen keys; window: pick reused keys from the
   // newest window entries of the pool (0 = whole pool)
   task automatic random_phase(input int count, input logic [CAP_W-1:0] cap,
                               input int fresh_pct, input int window,
                               input int upd_pct, input int del_pct, input bit hold_rsp);
      logic [CMD_W-1:0]   cmd;
      logic [FIELD_W-1:0] key;
      logic [FIELD_W-1:0] value;
      logic [COND_W-1:0]  cond;
      int pick;
      int low;
      set_capacity(cap);
      if (hold_rsp) hold_off_req = 1'b1;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 3) cmd = CMD_UNUSED;
         else if (pick < 3 + upd_pct) cmd = CMD_UPDATE;
         else if (pick < 3 + upd_pct + del_pct) cmd = CMD_DELETE;
         else cmd = CMD_LOOKUP;
         if (key_pool.size() == 0 || $urandom_range(99) < fresh_pct) begin
            key = {$urandom(), $urandom()};
            key_pool.push_back(key);
         end else begin
            low = (window == 0 || window >= key_pool.size()) ? 0 : key_pool.size() - window;
            key = key_pool[$urandom_range(key_pool.size() - 1, low)];
         end
         value = {$urandom(), $urandom()};
         if ($urandom_range(99) < 60) cond = COND_NONE;
         else cond = COND_W'($urandom_range(3, 1));
         send_command(cmd, key, value, cond, 1'b0, '0);
      end
   endtask

   // result side: random stalls, a long hold-off on request, and checking
   initial begin
      table_result_type want;
      status_type  got_status;
      logic [FIELD_W-1:0] got_value;
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got_status = status_type'(rsp_tdata[STATUS_W-1:0]);
            got_value  = rsp_tdata[STATUS_W +: FIELD_W];
            if (expected_results.size() == 0) begin
               $display("%0t: result with nothing expected: status=%0d value=%h",
                        $time, got_status, got_value);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (got_status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d actual %0d",
                           $time, want.status, got_status);
                  error_count++;
               end
               if (got_value !== want.value) begin
                  $display("%0t: read_value mismatch: expected %h actual %h",
                           $time, want.value, got_value);
                  error_count++;
               end
            end
         end
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            stall_left = $urandom_range(5, 0);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #(2_000_000);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      table_result_type typed_result;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      step(CMD_LOOKUP, '0, ALL_ONES, COND_BOTH, 1'b1, ST_NOT_FOUND);
      step(CMD_DELETE, ALL_ONES, '0, COND_NONE, 1'b1, ST_OK);
      step(CMD_UPDATE, '0, ALL_ONES, COND_NONE, 1'b1, ST_OK);
      step(CMD_LOOKUP, '0, '0, COND_NONE, 1'b1, ST_OK, ALL_ONES);
      step(CMD_UPDATE, ALL_ONES, '0, COND_NONE, 1'b1, ST_OK);
      step(CMD_LOOKUP, ALL_ONES, PATTERN_A, COND_NONE, 1'b1, ST_OK, '0);
      step(CMD_UPDATE, '0, 64'h1, COND_ABSENT_ONLY, 1'b1, ST_EXISTS);
      step(CMD_UPDATE, 64'h5, 64'h1, COND_PRESENT_ONLY, 1'b1, ST_NOT_FOUND);
      step(CMD_UPDATE, '0, 64'h1, COND_BOTH, 1'b1, ST_EXISTS);
      step(CMD_UPDATE, 64'h6, 64'h1, COND_BOTH, 1'b1, ST_NOT_FOUND);
      step(CMD_UPDATE, '0, PATTERN_5, COND_PRESENT_ONLY);
      step(CMD_UNUSED, '0, ALL_ONES, COND_BOTH, 1'b1, ST_OK);
      step(CMD_LOOKUP, '0, '0, COND_NONE);
      step(CMD_DELETE, '0, '0, COND_NONE);
      step(CMD_LOOKUP, '0, '0, COND_NONE, 1'b1, ST_NOT_FOUND);
      step(CMD_UPDATE, PATTERN_A, PATTERN_A, COND_ABSENT_ONLY);
      // zero capacity: new keys refused, replacing an existing value still works
      cap_step('0);
      step(CMD_UPDATE, 64'h7, 64'h7, COND_NONE, 1'b1, ST_FULL);
      step(CMD_UPDATE, ALL_ONES, PATTERN_5, COND_NONE);
      // capacity below live count: inserts fail until deletes make room
      cap_step(9'd1);
      step(CMD_UPDATE, 64'h7, 64'h7, COND_NONE, 1'b1, ST_FULL);
      step(CMD_DELETE, PATTERN_A, '0, COND_NONE);
      step(CMD_UPDATE, 64'h7, 64'h7, COND_NONE, 1'b1, ST_FULL);
      step(CMD_DELETE, ALL_ONES, '0, COND_NONE);
      step(CMD_UPDATE, 64'h7, 64'h7, COND_NONE);
      step(CMD_LOOKUP, 64'h7, '0, COND_NONE);

      foreach (script[i]) begin
         if (script[i].is_cap) begin
            set_capacity(script[i].cap);
         end else begin
            typed_result = script[i].result;
            send_command(script[i].cmd, script[i].key, script[i].value, script[i].cond,
                         script[i].typed, typed_result);
         end
      end

      random_phase(120, 9'd4, 10, 8, 50, 20, 1'b0);
      // capacity set past the table size, so the table size is the limit on inserts
      idle_pct = 0;
      random_phase(330, 9'd511, 85, 0, 88, 3, 1'b0);
      idle_pct = 25;
      random_phase(100, 9'd16, 5, 0, 40, 50, 1'b1);
      random_phase(140, 9'd256, 15, 32, 45, 20, 1'b0);
      idle_pct = 0;
      random_phase(80, 9'd2, 10, 6, 50, 20, 1'b0);

      wait_drained();
      repeat (TABLE_ENTRIES + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
